// File: rtl/rsa_decrypt_word_assert.svh
// Assertion macros for the RSA decrypt block checker.
// Included by the checker module only.
`ifndef RSA_DECRYPT_WORD_ASSERT_SVH
`define RSA_DECRYPT_WORD_ASSERT_SVH
// Implication held on every rising clock edge outside reset.
`define RDW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication held outside reset.
`define RDW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/rdw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the RSA decrypt block.
// No dependencies.
package rdw_pkg;
  localparam int unsigned PRIME_W = 16;
  localparam int unsigned WORD_W  = 31;
  localparam int unsigned PHI_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRIME_P = 2'd0,
    REG_PRIME_Q = 2'd1,
    REG_PUB_EXP = 2'd2,
    REG_MODULUS = 2'd3
  } cfg_reg_t;

  // Shared divider request and result.
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
    logic [31:0] rem;
  } div_rsp_t;
endpackage

// File: rtl/rdw_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the RSA decrypt block.
// Depends on rdw_pkg.
interface rdw_in_if import rdw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] cipher_word;
  modport source (output valid, output cipher_word, input ready);
  modport sink (input valid, input cipher_word, output ready);
endinterface

interface rdw_out_if import rdw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] plain_word;
  logic              no_inverse;
  modport source (output valid, output plain_word, output no_inverse, input ready);
  modport sink (input valid, input plain_word, input no_inverse, output ready);
endinterface

interface rdw_cfg_if import rdw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/rdw_divider.sv
`timescale 1ns / 1ps
// Restoring radix-2 divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
// Depends on rdw_pkg. Divisor must be nonzero.
module rdw_divider import rdw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [63:0] quot_r, quot_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] shifted;

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[31:0], quot_r[63]};
    if (req.start) begin
      quot_nxt = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt  = shifted - {1'b0, dvs_r};
        quot_nxt = {quot_r[62:0], 1'b1};
      end else begin
        rem_nxt  = shifted;
        quot_nxt = {quot_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r[31:0];
endmodule

// File: rtl/rdw_sequencer.sv
`timescale 1ns / 1ps
// Sequencer: phi, extended Euclid for d, then square and multiply; each division
// and reduction goes through the shared divider. Depends on rdw_pkg and rdw_divider.
module rdw_sequencer import rdw_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] cipher,
  input  logic [PRIME_W-1:0] prime_p,
  input  logic [PRIME_W-1:0] prime_q,
  input  logic [WORD_W-1:0] pub_exp,
  input  logic [WORD_W-1:0] modulus,
  output logic              busy,
  output logic              done,
  output logic [WORD_W-1:0] plain,
  output logic              no_inv
);
  localparam int unsigned EXP_BITS = (DATA_WIDTH < 64) ? DATA_WIDTH : 64;
  localparam int unsigned CNT_W = $clog2(EXP_BITS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_PHI, S_EMOD, S_EUC, S_EUC_UPD, S_TFIX, S_BASE,
    S_MUL, S_SQR, S_NEXT, S_DONE
  } state_t;

  state_t state_r;
  div_req_t req;
  div_rsp_t rsp;
  logic [PHI_W-1:0] phi_r, r0_r, r1_r;
  logic signed [33:0] t0_r, t1_r;
  logic [63:0] d_r;
  logic [WORD_W-1:0] base_r, res_r;
  logic [CNT_W-1:0] bit_r;
  logic [WORD_W-1:0] plain_r;
  logic no_inv_r, done_r, wait_r;
  logic [PRIME_W-1:0] pm1, qm1;
  logic signed [67:0] qt_prod;
  logic signed [33:0] t_new;
  logic signed [33:0] t_fix;

  rdw_divider u_div (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  assign pm1 = prime_p - PRIME_W'(1);
  assign qm1 = prime_q - PRIME_W'(1);
  assign qt_prod = $signed({1'b0, rsp.quot[32:0]}) * t1_r;
  assign t_new = t0_r - qt_prod[33:0];
  assign t_fix = (t0_r < 0) ? t0_r + $signed({2'b0, phi_r}) : t0_r;

  always_comb begin
    req = '0;
    if (!wait_r) begin
      case (state_r)
        S_EMOD: begin
          req.start = 1'b1; req.dividend = 64'(pub_exp); req.divisor = phi_r;
        end
        S_EUC: begin
          req.start = 1'b1; req.dividend = 64'(r0_r); req.divisor = r1_r;
        end
        S_BASE: begin
          req.start = 1'b1; req.dividend = 64'(cipher); req.divisor = 32'(modulus);
        end
        S_MUL: begin
          req.start = 1'b1; req.dividend = 64'(res_r) * 64'(base_r);
          req.divisor = 32'(modulus);
        end
        S_SQR: begin
          req.start = 1'b1; req.dividend = 64'(base_r) * 64'(base_r);
          req.divisor = 32'(modulus);
        end
        default: req = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      wait_r  <= 1'b0;
    end else begin
      done_r <= (state_r == S_DONE);
      case (state_r)
        S_IDLE: if (start) state_r <= S_PHI;
        S_PHI: begin
          if (prime_p < PRIME_W'(2) || prime_q < PRIME_W'(2)) begin
            phi_r <= '0;
            no_inv_r <= 1'b1; plain_r <= '0; state_r <= S_DONE;
          end else begin
            phi_r <= PHI_W'(pm1) * PHI_W'(qm1);
            r0_r  <= PHI_W'(pm1) * PHI_W'(qm1);
            state_r <= S_EMOD;
          end
        end
        S_EMOD, S_EUC, S_BASE, S_MUL, S_SQR: begin
          if (!wait_r) wait_r <= 1'b1;
          else if (rsp.done) begin
            wait_r <= 1'b0;
            case (state_r)
              S_EMOD: begin
                r1_r <= rsp.rem; t0_r <= '0; t1_r <= 34'sd1;
                state_r <= (rsp.rem == '0) ? S_TFIX : S_EUC;
              end
              S_EUC: state_r <= S_EUC_UPD;
              S_BASE: begin
                base_r <= rsp.rem[WORD_W-1:0];
                res_r <= (modulus == WORD_W'(1)) ? '0 : WORD_W'(1);
                bit_r <= '0;
                state_r <= (d_r[0]) ? S_MUL : S_SQR;
              end
              S_MUL: begin res_r <= rsp.rem[WORD_W-1:0]; state_r <= S_SQR; end
              default: begin base_r <= rsp.rem[WORD_W-1:0]; state_r <= S_NEXT; end
            endcase
          end
        end
        S_EUC_UPD: begin
          r0_r <= r1_r; r1_r <= rsp.rem;
          t0_r <= t1_r; t1_r <= t_new;
          state_r <= (rsp.rem == '0) ? S_TFIX : S_EUC;
        end
        S_TFIX: begin
          if (r0_r != PHI_W'(1)) begin
            no_inv_r <= 1'b1; plain_r <= '0; state_r <= S_DONE;
          end else begin
            no_inv_r <= 1'b0;
            d_r <= 64'(t_fix[31:0]);
            if (modulus == '0) begin
              plain_r <= '0; state_r <= S_DONE;
            end else state_r <= S_BASE;
          end
        end
        S_NEXT: begin
          if (bit_r == CNT_W'(EXP_BITS - 1)) begin
            plain_r <= res_r; state_r <= S_DONE;
          end else begin
            bit_r <= bit_r + CNT_W'(1);
            state_r <= (d_r[6'(bit_r + CNT_W'(1))]) ? S_MUL : S_SQR;
          end
        end
        S_DONE: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy  = (state_r != S_IDLE);
  assign done  = done_r;
  assign plain = plain_r;
  assign no_inv = no_inv_r;
endmodule

// File: rtl/rsa_decrypt_word.sv
`timescale 1ns / 1ps
// RSA decrypt of one word: d = e^-1 mod (p-1)(q-1) by extended Euclid, then
// c^d mod n by right-to-left square and multiply. One request at a time; every
// reduction goes through a single bit-serial 64/32 divider. Extended Euclid
// takes up to about 46 division steps; each exponent bit of d takes a squaring,
// plus a multiply when that bit is set. Without an inverse, or with a zero
// modulus, a request ends without the exponentiation. The result sits in an
// output register until taken, and no new request is accepted before then.
module rsa_decrypt_word import rdw_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  rdw_in_if.sink     in_ch,
  rdw_out_if.source  out_ch,
  rdw_cfg_if.sink    cfg_ch
);
  logic [PRIME_W-1:0] prime_p_r, prime_q_r;
  logic [WORD_W-1:0]  pub_exp_r, modulus_r, cipher_r;
  logic               out_valid_r, busy, done, no_inv;
  logic [WORD_W-1:0]  plain;
  logic               start_r;

  assign in_ch.ready = !busy && !out_valid_r && !start_r && !done;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_p_r <= PRIME_W'(2);
      prime_q_r <= PRIME_W'(2);
      pub_exp_r <= WORD_W'(1);
      modulus_r <= WORD_W'(1);
      start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= in_ch.valid && in_ch.ready;
      if (cfg_ch.valid) begin
        case (cfg_reg_t'(cfg_ch.index))
          REG_PRIME_P: prime_p_r <= cfg_ch.data[PRIME_W-1:0];
          REG_PRIME_Q: prime_q_r <= cfg_ch.data[PRIME_W-1:0];
          REG_PUB_EXP: pub_exp_r <= cfg_ch.data[WORD_W-1:0];
          REG_MODULUS: modulus_r <= cfg_ch.data[WORD_W-1:0];
          default: ;
        endcase
      end
      if (done) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
    if (in_ch.valid && in_ch.ready) cipher_r <= in_ch.cipher_word;
    if (done) begin
      out_ch.plain_word <= plain;
      out_ch.no_inverse <= no_inv;
    end
  end

  rdw_sequencer #(.DATA_WIDTH(DATA_WIDTH)) u_seq (
    .clk(clk), .rst_n(rst_n), .start(start_r), .cipher(cipher_r),
    .prime_p(prime_p_r), .prime_q(prime_q_r), .pub_exp(pub_exp_r),
    .modulus(modulus_r), .busy(busy), .done(done), .plain(plain), .no_inv(no_inv)
  );
endmodule

// File: rtl/rdw_checker.sv
`timescale 1ns / 1ps
// Port-level checker for rsa_decrypt_word, bound to the top level.
// Depends on rdw_pkg and rsa_decrypt_word_assert.svh.
`include "rsa_decrypt_word_assert.svh"
module rdw_checker import rdw_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [WORD_W-1:0] plain_word,
  input logic              no_inverse
);
  `RDW_ASSERT_IMP(a_no_accept_while_out, clk, rst_n, out_valid, !in_ready)
  `RDW_ASSERT_IMP(a_noinv_zero, clk, rst_n, out_valid && no_inverse, plain_word == '0)
  `RDW_ASSERT_NXT(a_accept_busy, clk, rst_n, in_valid && in_ready, !in_ready)
  `RDW_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

bind rsa_decrypt_word rdw_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .plain_word(out_ch.plain_word), .no_inverse(out_ch.no_inverse)
);

// File: tb/rsa_decrypt_word_tb.sv
`timescale 1ns / 1ps
// Testbench for rsa_decrypt_word: directed table then random requests, each result
// checked against a typed expectation or an in-bench RSA decrypt predictor.
// Depends on rdw_pkg, rdw_if.sv and rsa_decrypt_word.sv.
module rsa_decrypt_word_tb;
  import rdw_pkg::*;

  localparam int unsigned EXP_BITS = 32;
  localparam int unsigned TAIL_CYC = 50;

  typedef struct {
    logic [WORD_W-1:0] plain_word;
    logic              no_inverse;
  } plain_t;

  typedef struct {
    bit                do_cfg;
    logic [31:0]       p;
    logic [31:0]       q;
    logic [31:0]       e;
    logic [31:0]       n;
    logic [WORD_W-1:0] cipher;
    bit                typed;
    logic [WORD_W-1:0] plain_word;
    logic              no_inverse;
  } vec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rdw_in_if  in_ch ();
  rdw_out_if out_ch ();
  rdw_cfg_if cfg_ch ();

  rsa_decrypt_word dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  logic [PRIME_W-1:0] sh_p = 16'd2;
  logic [PRIME_W-1:0] sh_q = 16'd2;
  logic [WORD_W-1:0]  sh_e = 31'd1;
  logic [WORD_W-1:0]  sh_n = 31'd1;

  plain_t pending_plain[$];
  int     fail_count = 0;
  int     send_idle_pct = 6;
  int     recv_idle_pct = 52;
  bit     hold_req = 1'b0;
  int     hold_cnt = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic plain_t decrypt_word(input logic [WORD_W-1:0] c);
    plain_t r;
    longint phi, r0, r1, t0, t1, qt, tmp;
    longint unsigned b, acc, d, n;
    r.plain_word = '0;
    r.no_inverse = 1'b1;
    phi = 0;
    if (sh_p >= 2 && sh_q >= 2) phi = (longint'(sh_p) - 1) * (longint'(sh_q) - 1);
    if (phi == 0) return r;
    r0 = phi;
    r1 = longint'(sh_e) % phi;
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      qt = r0 / r1;
      tmp = r0 - qt * r1;
      r0 = r1;
      r1 = tmp;
      tmp = t0 - qt * t1;
      t0 = t1;
      t1 = tmp;
    end
    if (r0 != 1) return r;
    t0 = t0 % phi;
    if (t0 < 0) t0 += phi;
    d = longint'(t0);
    r.no_inverse = 1'b0;
    n = longint'(sh_n);
    if (n == 0) return r;
    b = longint'(c) % n;
    acc = 1 % n;
    for (int i = 0; i < EXP_BITS; i++) begin
      if (d[i]) acc = (acc * b) % n;
      b = (b * b) % n;
    end
    r.plain_word = acc[WORD_W-1:0];
    return r;
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_PRIME_P: sh_p = data[PRIME_W-1:0];
      REG_PRIME_Q: sh_q = data[PRIME_W-1:0];
      REG_PUB_EXP: sh_e = data[WORD_W-1:0];
      REG_MODULUS: sh_n = data[WORD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic load_key(input logic [31:0] p, q, e, n);
    write_reg(REG_PRIME_P, p);
    write_reg(REG_PRIME_Q, q);
    write_reg(REG_PUB_EXP, e);
    write_reg(REG_MODULUS, n);
  endtask

  // Lower valid and let every outstanding request complete.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_plain.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
  endtask

  task automatic send_cipher(input logic [WORD_W-1:0] c, input bit typed,
                             input plain_t typed_plain);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.cipher_word <= c;
    do @(posedge clk); while (!in_ch.ready);
    pending_plain.push_back(typed ? typed_plain : decrypt_word(c));
  endtask

  function automatic logic [31:0] pick_prime_reg();
    case ($urandom_range(9))
      0: return {16'($urandom_range(65535)), 16'd0};
      1: return 32'd1 | ($urandom & 32'hFFFF_0000);
      2: return 32'd2;
      3: return 32'd65535;
      default: return {16'($urandom_range(65535)), 16'($urandom_range(65535, 2))};
    endcase
  endfunction

  function automatic logic [31:0] pick_word_reg(input bit is_modulus);
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(1000, 2);
      default: return is_modulus ? $urandom : ($urandom | 32'd1);
    endcase
  endfunction

  always @(negedge clk) begin
    if (hold_req && hold_cnt == 0) hold_cnt = 30000;
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    plain_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_plain.size() == 0) begin
        report_mismatch($sformatf("unexpected result plain=%0h", out_ch.plain_word));
      end else begin
        want = pending_plain.pop_front();
        if (out_ch.plain_word !== want.plain_word)
          report_mismatch($sformatf("plain_word got %0h want %0h",
                                    out_ch.plain_word, want.plain_word));
        if (out_ch.no_inverse !== want.no_inverse)
          report_mismatch($sformatf("no_inverse got %0b want %0b",
                                    out_ch.no_inverse, want.no_inverse));
      end
    end
  end

  vec_t vecs[$] = '{
    '{0, 0, 0, 0, 0, 31'h7FFF_FFFF, 1, 31'd0, 1'b0},
    '{1, 61, 53, 17, 3233, 31'd2790, 1, 31'd65, 1'b0},
    '{0, 0, 0, 0, 0, 31'd6023, 1, 31'd65, 1'b0},
    '{1, 0, 53, 17, 3233, 31'd2790, 1, 31'd0, 1'b1},
    '{1, 61, 1, 17, 3233, 31'd2790, 1, 31'd0, 1'b1},
    '{1, 61, 53, 20, 3233, 31'd2790, 1, 31'd0, 1'b1},
    '{1, 61, 53, 17, 0, 31'd2790, 1, 31'd0, 1'b0},
    '{1, 61, 53, 20, 0, 31'd2790, 1, 31'd0, 1'b1},
    '{1, 2, 2, 32'h7FFF_FFFF, 5, 31'd3, 1, 31'd1, 1'b0},
    '{1, 2, 2, 0, 1, 31'd3, 1, 31'd0, 1'b0},
    '{1, 65535, 65535, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFE, 0, 0, 0},
    '{0, 0, 0, 0, 0, 31'd0, 0, 0, 0},
    '{1, 65535, 2, 1, 32'h7FFF_FFFF, 31'h5555_5555, 0, 0, 0},
    '{1, 2, 65535, 65537, 32'hFFFF_FFFF, 31'h2AAA_AAAA, 0, 0, 0},
    '{1, 65521, 65519, 65537, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 0, 0},
    '{1, 32'hFFFF_FFFF, 32'hFFFF_0061, 32'hFFFF_FFFF, 32'h8000_0CA1, 31'd1, 0, 0, 0},
    '{1, 61, 53, 0, 3233, 31'd7, 1, 31'd0, 1'b1}
  };

  initial begin
    plain_t tp;
    in_ch.valid       <= 1'b0;
    in_ch.cipher_word <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= REG_PRIME_P;
    cfg_ch.data       <= '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (vecs[i]) begin
      if (vecs[i].do_cfg) begin
        drain();
        load_key(vecs[i].p, vecs[i].q, vecs[i].e, vecs[i].n);
      end
      tp.plain_word = vecs[i].plain_word;
      tp.no_inverse = vecs[i].no_inverse;
      send_cipher(vecs[i].cipher, vecs[i].typed, tp);
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 52 : 0;
      recv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 6 : 0;
      for (int k = 0; k < 4; k++) begin
        drain();
        load_key(pick_prime_reg(), pick_prime_reg(), pick_word_reg(0), pick_word_reg(1));
        if (ph == 2 && k == 0) hold_req = 1'b1;
        for (int j = 0; j < 10; j++) begin
          send_cipher(WORD_W'($urandom), 0, tp);
          hold_req = 1'b0;
        end
      end
    end

    drain();
    if (fail_count == 0 && pending_plain.size() == 0) begin
      $display("rsa_decrypt_word_tb: PASS");
    end else begin
      $display("rsa_decrypt_word_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("rsa_decrypt_word_tb: FAIL");
    $finish;
  end
endmodule
